// ----- rtl/core/cbc_pkg.sv -----
// ---------------------------------------------------------------------------
// cbc_pkg: shared types and constants of the cell balancing controller
// Register indexes, state codes, request codes and reset values.
// ---------------------------------------------------------------------------
package cbc_pkg;

   localparam int NumCellsDef = 16;

   // register indexes
   localparam logic [2:0] REG_THRESH  = 3'd0;
   localparam logic [2:0] REG_HYST    = 3'd1;
   localparam logic [2:0] REG_REST_MA = 3'd2;
   localparam logic [2:0] REG_REST_TK = 3'd3;
   localparam logic [2:0] REG_LOWER   = 3'd4;
   localparam logic [2:0] REG_SHORT   = 3'd5;
   localparam logic [2:0] REG_LONG    = 3'd6;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_REQ   = 2'd1;
   localparam logic [1:0] KIND_CELL  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // main states
   localparam logic [2:0] ST_UNINIT    = 3'd0;
   localparam logic [2:0] ST_INIT      = 3'd1;
   localparam logic [2:0] ST_INITED    = 3'd2;
   localparam logic [2:0] ST_INACTIVE  = 3'd3;
   localparam logic [2:0] ST_ACTIVE    = 3'd4;
   localparam logic [2:0] ST_INACT_OVR = 3'd5;
   localparam logic [2:0] ST_ACT_OVR   = 3'd6;

   // substates
   localparam logic [1:0] SUB_ENTRY    = 2'd0;
   localparam logic [1:0] SUB_BAL_ON   = 2'd1;
   localparam logic [1:0] SUB_BAL_OFF  = 2'd2;
   localparam logic [1:0] SUB_FINISHED = 2'd3;

   // pending request: code + 1, zero means none
   localparam logic [3:0] PQ_NONE          = 4'd0;
   localparam logic [3:0] PQ_INIT          = 4'd1;
   localparam logic [3:0] PQ_ACTIVE        = 4'd2;
   localparam logic [3:0] PQ_INACTIVE      = 4'd3;
   localparam logic [3:0] PQ_ACT_OVR       = 4'd4;
   localparam logic [3:0] PQ_INACT_OVR     = 4'd5;
   localparam logic [3:0] PQ_STOP_TO_ACT   = 4'd6;
   localparam logic [3:0] PQ_STOP_TO_INACT = 4'd7;

   // request codes
   localparam logic [2:0] RQ_INIT          = 3'd0;
   localparam logic [2:0] RQ_ACTIVE        = 3'd1;
   localparam logic [2:0] RQ_INACTIVE      = 3'd2;
   localparam logic [2:0] RQ_ACT_OVR       = 3'd3;
   localparam logic [2:0] RQ_INACT_OVR     = 3'd4;
   localparam logic [2:0] RQ_STOP_TO_ACT   = 3'd5;
   localparam logic [2:0] RQ_STOP_TO_INACT = 3'd6;
   localparam logic [2:0] RQ_ERROR         = 3'd7;

   // request status
   localparam logic [1:0] RS_OK      = 2'd0;
   localparam logic [1:0] RS_ALREADY = 2'd1;
   localparam logic [1:0] RS_PENDING = 2'd3;

   // register reset values
   localparam logic [15:0] THRESH_RST  = 16'd10;
   localparam logic [15:0] HYST_RST    = 16'd10;
   localparam logic [18:0] REST_MA_RST = 19'd200;
   localparam logic [23:0] REST_TK_RST = 24'd6000;
   localparam logic [15:0] LOWER_RST   = 16'd3000;
   localparam logic [15:0] SHORT_RST   = 16'd10;
   localparam logic [15:0] LONG_RST    = 16'd100;

   // one-hot control sequencer
   typedef enum logic [3:0] {
      CS_IDLE  = 4'b0001,
      CS_SCAN  = 4'b0010,
      CS_STEP  = 4'b0100,
      CS_OUT   = 4'b1000
   } ctl_state_type;

endpackage

// ----- rtl/core/cell_balancing_controller.sv -----
// ---------------------------------------------------------------------------
// cell_balancing_controller: passive cell balancing with hysteresis
// Flow: request, cell write and a tick that leaves the wait timer running
// pass from the input beat to the out state and then the result beat; other
// ticks run scan (one cell-store memory read per scan step), step, then out.
// Flow control: one item at a time; the next input beat is taken only after
// the result beat has been accepted.
// Reset (synchronous): registers to defaults, state uninitialized, cell store
// cleared by valid bits, no clearing pass.
// ---------------------------------------------------------------------------
module cell_balancing_controller
   import cbc_pkg::*;
#(
   parameter int NUM_CELLS = NumCellsDef
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [2:0] request_code, [6:3] cell_index, [22:7] cell_voltage_mv,
   //            [42:23] pack_current_ma, [58:43] min_cell_mv
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // req_tuser: [1:0] req_type
   input  logic [1:0]  req_tuser,
   // rsp_tdata: [1:0] request_status, [4:2] main_state, [6:5] sub_state,
   //            [22:7] balance_mask, [23] balancing_on, [24] pack_resting,
   //            [32:25] bad_request_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int CW = $clog2(NUM_CELLS + 1);
   localparam int MW = (NUM_CELLS < 64) ? NUM_CELLS : 64;

   // configuration registers
   logic [15:0] thresh_ff, hyst_ff, lower_ff, short_ff, long_ff;
   logic [18:0] rest_ma_ff;
   logic [23:0] rest_tk_ff;
   logic        wr_en;
   logic [2:0]  wr_idx;

   assign csr_pready = 1'b1;
   assign wr_idx = csr_paddr[4:2];
   assign wr_en  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= THRESH_RST;
         hyst_ff    <= HYST_RST;
         rest_ma_ff <= REST_MA_RST;
         rest_tk_ff <= REST_TK_RST;
         lower_ff   <= LOWER_RST;
         short_ff   <= SHORT_RST;
         long_ff    <= LONG_RST;
      end else if (wr_en) begin
         case (wr_idx)
            REG_THRESH:  thresh_ff  <= csr_pwdata[15:0];
            REG_HYST:    hyst_ff    <= csr_pwdata[15:0];
            REG_REST_MA: rest_ma_ff <= csr_pwdata[18:0];
            REG_REST_TK: rest_tk_ff <= csr_pwdata[23:0];
            REG_LOWER:   lower_ff   <= csr_pwdata[15:0];
            REG_SHORT:   short_ff   <= csr_pwdata[15:0];
            REG_LONG:    long_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (wr_idx)
            REG_THRESH:  csr_prdata = {16'd0, thresh_ff};
            REG_HYST:    csr_prdata = {16'd0, hyst_ff};
            REG_REST_MA: csr_prdata = {13'd0, rest_ma_ff};
            REG_REST_TK: csr_prdata = {8'd0, rest_tk_ff};
            REG_LOWER:   csr_prdata = {16'd0, lower_ff};
            REG_SHORT:   csr_prdata = {16'd0, short_ff};
            REG_LONG:    csr_prdata = {16'd0, long_ff};
            default:     csr_prdata = '0;
         endcase
      end
   end

   // input fields
   logic [15:0] in_volt, in_min;
   logic [19:0] in_cur;
   logic [2:0]  in_code;
   logic [3:0]  in_idx;
   assign in_code = req_tdata[2:0];
   assign in_idx  = req_tdata[6:3];
   assign in_volt = req_tdata[22:7];
   assign in_cur  = req_tdata[42:23];
   assign in_min  = req_tdata[58:43];

   // sequencer state
   ctl_state_type cs_ff, cs_in;
   logic [2:0]  seq_ff, seq_in;
   logic [1:0]  sub_ff, sub_in;
   logic [15:0] wait_ff, wait_in;
   logic [23:0] rcnt_ff, rcnt_in;
   logic        rest_ff, rest_in, act_ff, act_in;
   logic [16:0] lthr_ff, lthr_in;
   logic [3:0]  pend_ff, pend_in;
   logic [7:0]  err_ff, err_in;
   logic [MW-1:0] mask_ff, mask_in;
   logic [1:0]  stat_ff, stat_in;
   logic [15:0] min_ff;
   logic        scan_need_ff, scan_need_in;
   logic [MW-1:0] scan_ff, scan_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NUM_CELLS-1:0] vld_ff;
   logic        rvld_ff;

   // cell store memory: written on cell beats, read one cell per scan cycle
   logic [15:0] mem [NUM_CELLS];
   logic [15:0] rd_ff;
   logic        mem_we;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;

   assign mem_we  = req_tvalid && req_tready && (req_tuser == KIND_CELL)
                    && ({28'd0, in_idx} < 32'(NUM_CELLS));
   assign wr_addr = IW'(in_idx);
   assign rd_addr = cnt_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= in_volt;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (mem_we) vld_ff[wr_addr] <= 1'b1;
   end

   logic [17:0] limit;
   logic [15:0] cell_val;
   logic [19:0] mag;
   logic [15:0] wait_dec;
   logic        mask_zero;
   assign limit     = {2'b00, min_ff} + {1'b0, lthr_ff};
   assign wait_dec  = (wait_ff != 16'd0) ? wait_ff - 16'd1 : wait_ff;
   assign mag       = in_cur[19] ? (20'd0 - in_cur) : in_cur;
   assign mask_zero = (scan_ff == '0);

   assign req_tready = (cs_ff == CS_IDLE) && !rsp_tvalid;

   always_comb begin
      cs_in = cs_ff; seq_in = seq_ff; sub_in = sub_ff; wait_in = wait_ff;
      rcnt_in = rcnt_ff; rest_in = rest_ff; act_in = act_ff; lthr_in = lthr_ff;
      pend_in = pend_ff; err_in = err_ff; mask_in = mask_ff; stat_in = stat_ff;
      scan_need_in = scan_need_ff; scan_in = scan_ff; cnt_in = cnt_ff;
      cell_val = '0;
      case (cs_ff)
         CS_IDLE: begin
            if (req_tvalid && req_tready) begin
               stat_in = RS_OK;
               cs_in = CS_OUT;
               case (req_tuser)
                  KIND_TICK: begin
                     // timers and rest detection; sequencer runs after scan
                     if (rcnt_ff != 24'd0) rcnt_in = rcnt_ff - 24'd1;
                     wait_in = wait_dec;
                     if (wait_dec == 16'd0) begin
                        if (mag < {1'b0, rest_ma_ff}) begin
                           if (!rest_ff) begin
                              rest_in = 1'b1;
                              rcnt_in = rest_tk_ff;
                           end
                        end else begin
                           rest_in = 1'b0;
                        end
                        scan_need_in = 1'b1;
                        scan_in = '0;
                        cnt_in = '0;
                        cs_in = CS_SCAN;
                     end
                  end
                  KIND_REQ: begin
                     if (in_code == RQ_ERROR) stat_in = RS_OK;
                     else if (pend_ff != PQ_NONE) stat_in = RS_PENDING;
                     else if (in_code == RQ_INIT)
                        stat_in = (seq_ff == ST_UNINIT) ? RS_OK : RS_ALREADY;
                     else stat_in = RS_OK;
                     if (stat_in == RS_OK) pend_in = {1'b0, in_code} + 4'd1;
                  end
                  default: ;
               endcase
            end
         end
         CS_SCAN: begin
            // rd_ff holds cell cnt_ff-1 once the first read has returned
            if (cnt_ff != '0) begin
               cell_val = vld_ff[cnt_ff[IW-1:0] - IW'(1)] ? rd_ff : 16'd0;
               if ({2'b00, cell_val} > limit && (cnt_ff - CW'(1)) < CW'(MW))
                  scan_in[cnt_ff[IW-1:0] - IW'(1)] = 1'b1;
            end
            if (cnt_ff == CW'(NUM_CELLS)) cs_in = CS_STEP;
            else cnt_in = cnt_ff + CW'(1);
         end
         CS_STEP: begin
            cs_in = CS_OUT;
            case (seq_ff)
               ST_UNINIT: begin
                  pend_in = PQ_NONE;
                  if (pend_ff == PQ_INIT) begin
                     wait_in = short_ff; seq_in = ST_INIT; sub_in = SUB_ENTRY;
                  end else if (pend_ff != PQ_NONE) err_in = err_ff + 8'd1;
               end
               ST_INIT: begin
                  wait_in = short_ff; seq_in = ST_INITED; sub_in = SUB_ENTRY;
               end
               ST_INITED: begin
                  wait_in = short_ff; seq_in = ST_INACTIVE; sub_in = SUB_ENTRY;
               end
               ST_INACTIVE: begin
                  if (act_ff) begin mask_in = '0; act_in = 1'b0; end
                  wait_in = short_ff;
                  pend_in = PQ_NONE;
                  if (pend_ff == PQ_ACT_OVR) begin
                     seq_in = ST_ACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_INACT_OVR) begin
                     seq_in = ST_INACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_ACTIVE) begin
                     seq_in = ST_ACTIVE; sub_in = SUB_ENTRY;
                  end
               end
               ST_ACTIVE: begin
                  wait_in = short_ff;
                  pend_in = PQ_NONE;
                  if (pend_ff == PQ_ACT_OVR) begin
                     seq_in = ST_ACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_INACT_OVR) begin
                     seq_in = ST_INACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_INACTIVE) begin
                     seq_in = ST_INACTIVE; sub_in = SUB_ENTRY;
                  end else begin
                     case (sub_ff)
                        SUB_ENTRY:
                           sub_in = (rest_ff && rcnt_ff == 24'd0) ? SUB_BAL_ON
                                                                  : SUB_BAL_OFF;
                        SUB_BAL_ON: begin
                           if (min_ff < lower_ff) sub_in = SUB_BAL_OFF;
                           else begin
                              mask_in = scan_ff;
                              if (!mask_zero) begin
                                 act_in = 1'b1;
                                 lthr_in = {1'b0, thresh_ff};
                                 sub_in = SUB_ENTRY;
                              end else sub_in = SUB_FINISHED;
                           end
                        end
                        SUB_BAL_OFF: begin
                           if (act_ff) begin
                              mask_in = '0;
                              lthr_in = {1'b0, thresh_ff} + {1'b0, hyst_ff};
                              act_in = 1'b0;
                           end
                           sub_in = SUB_ENTRY;
                        end
                        default: begin
                           if (act_ff) mask_in = '0;
                           lthr_in = {1'b0, thresh_ff} + {1'b0, hyst_ff};
                           act_in = 1'b0;
                           wait_in = long_ff;
                           sub_in = SUB_ENTRY;
                        end
                     endcase
                  end
               end
               ST_INACT_OVR: begin
                  mask_in = '0; act_in = 1'b0; wait_in = short_ff;
                  pend_in = PQ_NONE;
                  if (pend_ff == PQ_ACT_OVR) begin
                     seq_in = ST_ACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_STOP_TO_INACT) begin
                     seq_in = ST_INACTIVE; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_STOP_TO_ACT) begin
                     seq_in = ST_ACTIVE; sub_in = SUB_ENTRY;
                  end
               end
               ST_ACT_OVR: begin
                  wait_in = short_ff; mask_in = scan_ff; act_in = 1'b1;
                  pend_in = PQ_NONE;
                  if (mask_zero) begin
                     seq_in = ST_ACTIVE; sub_in = SUB_FINISHED;
                  end else if (pend_ff == PQ_INACT_OVR) begin
                     wait_in = short_ff; seq_in = ST_INACT_OVR; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_STOP_TO_INACT) begin
                     seq_in = ST_INACTIVE; sub_in = SUB_ENTRY;
                  end else if (pend_ff == PQ_STOP_TO_ACT) begin
                     seq_in = ST_ACTIVE; sub_in = SUB_ENTRY;
                  end
               end
               default: ;
            endcase
            scan_need_in = 1'b0;
         end
         CS_OUT: cs_in = CS_IDLE;
         default: cs_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= CS_IDLE; seq_ff <= ST_UNINIT; sub_ff <= SUB_ENTRY;
         wait_ff <= '0; rcnt_ff <= REST_TK_RST; rest_ff <= 1'b1; act_ff <= 1'b0;
         lthr_ff <= {1'b0, THRESH_RST} + {1'b0, HYST_RST};
         pend_ff <= PQ_NONE; err_ff <= '0; mask_ff <= '0; stat_ff <= RS_OK;
         scan_need_ff <= 1'b0; cnt_ff <= '0; rvld_ff <= 1'b0;
      end else begin
         cs_ff <= cs_in; seq_ff <= seq_in; sub_ff <= sub_in; wait_ff <= wait_in;
         rcnt_ff <= rcnt_in; rest_ff <= rest_in; act_ff <= act_in;
         lthr_ff <= lthr_in; pend_ff <= pend_in; err_ff <= err_in;
         mask_ff <= mask_in; stat_ff <= stat_in; scan_need_ff <= scan_need_in;
         cnt_ff <= cnt_in;
         if (cs_ff == CS_OUT) rvld_ff <= 1'b1;
         else if (rsp_tready) rvld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (req_tvalid && req_tready) begin
         min_ff <= in_min;
      end
   end

   // output beat
   logic [15:0] mask16;
   always_comb begin
      mask16 = '0;
      for (int i = 0; i < 16; i++)
         if (i < MW) mask16[i] = mask_ff[i % MW];
   end

   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = {7'd0, err_ff, rest_ff, act_ff, mask16, sub_ff, seq_ff, stat_ff};

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cs_ff != CS_IDLE) |-> !req_tready)
      else $error("input taken while busy");
   a_out_after_done: assert property (@(posedge clock) disable iff (reset)
      (cs_ff == CS_OUT) |=> rsp_tvalid)
      else $error("result not raised after item");
   a_scan_to_step: assert property (@(posedge clock) disable iff (reset)
      (cs_ff == CS_SCAN && cnt_ff == CW'(NUM_CELLS)) |=> (cs_ff == CS_STEP))
      else $error("scan did not end in step");
   a_step_scan_flag: assert property (@(posedge clock) disable iff (reset)
      (cs_ff == CS_STEP) |-> scan_need_ff)
      else $error("step without scan");

endmodule

// ----- dv/tb_cell_balancing_controller.sv -----
// ---------------------------------------------------------------------------
// tb_cell_balancing_controller: self-checking bench of the balancing block
// Drives request, cell write and tick beats over the req stream, predicts
// every rsp beat with a local model of the sequencer, and compares field by
// field. Registers are rewritten over the APB port between phases.
// ---------------------------------------------------------------------------
module tb_cell_balancing_controller;
   import cbc_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  code;
      logic [3:0]  idx;
      logic [15:0] volt;
      logic [19:0] cur;
      logic [15:0] minv;
   } item_t;

   // most significant field first, so it lines up with rsp_tdata[32:0]
   typedef struct packed {
      logic [7:0]  errs;
      logic        resting;
      logic        on;
      logic [15:0] mask;
      logic [1:0]  sub;
      logic [2:0]  main;
      logic [1:0]  status;
   } snap_t;

   // directed row: typed status/state are used where known
   typedef struct packed {
      item_t       it;
      logic        typed;
      logic [1:0]  status;
      logic [2:0]  main;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cell_balancing_controller u_dut (.*);

   always #10 clock = ~clock;

   // model registers and state
   logic [15:0] cfg_thresh, cfg_hyst, cfg_lower, cfg_short, cfg_long;
   logic [18:0] cfg_rest_ma;
   logic [23:0] cfg_rest_tk;
   logic [2:0]  mdl_main;
   logic [1:0]  bal_sub;
   logic [15:0] wait_cnt;
   logic [23:0] rest_cnt;
   logic        rest_flag, on_flag;
   logic [16:0] live_thr;
   logic [3:0]  pend_rq;
   logic [7:0]  err_cnt;
   logic [15:0] cells [16];
   logic [15:0] bleed;

   snap_t  expected_q [$];
   row_t   pending_rows [$];
   int     fails = 0;
   bit     quiet = 1'b0;
   int     base_mv = 3200;

   function automatic void model_reset();
      cfg_thresh = THRESH_RST; cfg_hyst = HYST_RST; cfg_rest_ma = REST_MA_RST;
      cfg_rest_tk = REST_TK_RST; cfg_lower = LOWER_RST; cfg_short = SHORT_RST;
      cfg_long = LONG_RST;
      mdl_main = ST_UNINIT; bal_sub = SUB_ENTRY; wait_cnt = '0;
      rest_cnt = REST_TK_RST; rest_flag = 1'b1; on_flag = 1'b0;
      live_thr = 17'(THRESH_RST) + 17'(HYST_RST);
      pend_rq = PQ_NONE; err_cnt = '0; bleed = '0;
      foreach (cells[i]) cells[i] = '0;
   endfunction

   function automatic logic [3:0] take_request();
      logic [3:0] r;
      r = pend_rq;
      pend_rq = PQ_NONE;
      return r;
   endfunction

   // returns 1 when no cell is above the limit
   function automatic bit bleed_scan(logic [15:0] minv);
      logic [17:0] lim;
      logic [15:0] m;
      lim = 18'(minv) + 18'(live_thr);
      m = '0;
      for (int i = 0; i < 16; i++) if (18'(cells[i]) > lim) m[i] = 1'b1;
      bleed = m;
      return m == '0;
   endfunction

   function automatic void go_state(logic [2:0] s);
      wait_cnt = cfg_short;
      mdl_main = s;
      bal_sub = SUB_ENTRY;
   endfunction

   function automatic void tick_step(logic [19:0] cur, logic [15:0] minv);
      logic [19:0] mag;
      logic [3:0]  rq;
      bit          done;
      if (rest_cnt != 0) rest_cnt--;
      if (wait_cnt != 0) begin
         wait_cnt--;
         if (wait_cnt != 0) return;
      end
      mag = cur[19] ? -cur : cur;
      if (mag < 20'(cfg_rest_ma)) begin
         if (!rest_flag) begin
            rest_flag = 1'b1;
            rest_cnt = cfg_rest_tk;
         end
      end else begin
         rest_flag = 1'b0;
      end
      case (mdl_main)
         ST_UNINIT: begin
            rq = take_request();
            if (rq == PQ_INIT) go_state(ST_INIT);
            else if (rq != PQ_NONE) err_cnt++;
         end
         ST_INIT: go_state(ST_INITED);
         ST_INITED: go_state(ST_INACTIVE);
         ST_INACTIVE: begin
            if (on_flag) begin
               bleed = '0;
               on_flag = 1'b0;
            end
            wait_cnt = cfg_short;
            rq = take_request();
            if (rq == PQ_ACT_OVR) go_state(ST_ACT_OVR);
            else if (rq == PQ_INACT_OVR) go_state(ST_INACT_OVR);
            else if (rq == PQ_ACTIVE) go_state(ST_ACTIVE);
         end
         ST_ACTIVE: begin
            wait_cnt = cfg_short;
            rq = take_request();
            if (rq == PQ_ACT_OVR) go_state(ST_ACT_OVR);
            else if (rq == PQ_INACT_OVR) go_state(ST_INACT_OVR);
            else if (rq == PQ_INACTIVE) go_state(ST_INACTIVE);
            else if (bal_sub == SUB_ENTRY) begin
               bal_sub = (rest_flag && rest_cnt == 0) ? SUB_BAL_ON : SUB_BAL_OFF;
            end else if (bal_sub == SUB_BAL_ON) begin
               if (minv < cfg_lower) begin
                  bal_sub = SUB_BAL_OFF;
               end else if (!bleed_scan(minv)) begin
                  on_flag = 1'b1;
                  live_thr = 17'(cfg_thresh);
                  bal_sub = SUB_ENTRY;
               end else begin
                  bal_sub = SUB_FINISHED;
               end
            end else if (bal_sub == SUB_BAL_OFF) begin
               if (on_flag) begin
                  bleed = '0;
                  live_thr = 17'(cfg_thresh) + 17'(cfg_hyst);
                  on_flag = 1'b0;
               end
               bal_sub = SUB_ENTRY;
            end else begin
               if (on_flag) bleed = '0;
               live_thr = 17'(cfg_thresh) + 17'(cfg_hyst);
               on_flag = 1'b0;
               wait_cnt = cfg_long;
               bal_sub = SUB_ENTRY;
            end
         end
         ST_INACT_OVR: begin
            bleed = '0;
            on_flag = 1'b0;
            wait_cnt = cfg_short;
            rq = take_request();
            if (rq == PQ_ACT_OVR) go_state(ST_ACT_OVR);
            else if (rq == PQ_STOP_TO_INACT) go_state(ST_INACTIVE);
            else if (rq == PQ_STOP_TO_ACT) go_state(ST_ACTIVE);
         end
         ST_ACT_OVR: begin
            wait_cnt = cfg_short;
            done = bleed_scan(minv);
            on_flag = 1'b1;
            rq = take_request();
            if (done) begin
               mdl_main = ST_ACTIVE;
               bal_sub = SUB_FINISHED;
            end else if (rq == PQ_INACT_OVR) go_state(ST_INACT_OVR);
            else if (rq == PQ_STOP_TO_INACT) go_state(ST_INACTIVE);
            else if (rq == PQ_STOP_TO_ACT) go_state(ST_ACTIVE);
         end
         default: ;
      endcase
   endfunction

   // request check; returns the status
   function automatic logic [1:0] post_request(logic [2:0] code);
      logic [1:0] st;
      if (code == RQ_ERROR) st = RS_OK;
      else if (pend_rq != PQ_NONE) st = RS_PENDING;
      else if (code == RQ_INIT) st = (mdl_main == ST_UNINIT) ? RS_OK : RS_ALREADY;
      else st = RS_OK;
      if (st == RS_OK) pend_rq = 4'(code) + 4'd1;
      return st;
   endfunction

   function automatic snap_t predict_balancer(item_t it);
      snap_t s;
      s.status = RS_OK;
      case (it.kind)
         KIND_TICK: tick_step(it.cur, it.minv);
         KIND_REQ:  s.status = post_request(it.code);
         KIND_CELL: cells[it.idx] = it.volt;
         default: ;
      endcase
      s.main = mdl_main; s.sub = bal_sub; s.mask = bleed;
      s.on = on_flag; s.resting = rest_flag; s.errs = err_cnt;
      return s;
   endfunction

   // accepted req beat: predict and queue the expected rsp beat
   always @(posedge clock) begin
      row_t  r;
      snap_t s;
      if (!reset && req_tvalid && req_tready) begin
         r = pending_rows.pop_front();
         s = predict_balancer(r.it);
         if (r.typed) begin
            s.status = r.status;
            s.main = r.main;
         end
         expected_q.push_back(s);
      end
   end

   // rsp side: random stall bursts, and compare each accepted beat
   int stall_left = 0;
   always @(posedge clock) begin
      snap_t e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = snap_t'(rsp_tdata[32:0]);
         if (expected_q.size() == 0) begin
            $error("rsp beat with nothing expected: %h", rsp_tdata);
            fails++;
         end else begin
            e = expected_q.pop_front();
            if (a.status !== e.status) begin
               $error("request_status exp %0d got %0d", e.status, a.status); fails++;
            end
            if (a.main !== e.main) begin
               $error("main_state exp %0d got %0d", e.main, a.main); fails++;
            end
            if (a.sub !== e.sub) begin
               $error("sub_state exp %0d got %0d", e.sub, a.sub); fails++;
            end
            if (a.mask !== e.mask) begin
               $error("balance_mask exp %h got %h", e.mask, a.mask); fails++;
            end
            if (a.on !== e.on) begin
               $error("balancing_on exp %0d got %0d", e.on, a.on); fails++;
            end
            if (a.resting !== e.resting) begin
               $error("pack_resting exp %0d got %0d", e.resting, a.resting); fails++;
            end
            if (a.errs !== e.errs) begin
               $error("bad_request_count exp %0d got %0d", e.errs, a.errs); fails++;
            end
         end
      end
      if (quiet || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if ($urandom_range(99) < 6) begin
         stall_left = $urandom_range(17, 1);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(item_t it, logic typed, logic [1:0] st, logic [2:0] ms);
      row_t r;
      r.it = it; r.typed = typed; r.status = st; r.main = ms;
      pending_rows.push_back(r);
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {5'd0, it.minv, it.cur, it.volt, it.idx, it.code};
      @(posedge clock iff (req_tvalid && req_tready));
      if (!quiet && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [2:0] regi, logic [31:0] val);
      req_tvalid <= 1'b0;
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {regi, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (regi)
         REG_THRESH:  cfg_thresh = val[15:0];
         REG_HYST:    cfg_hyst = val[15:0];
         REG_REST_MA: cfg_rest_ma = val[18:0];
         REG_REST_TK: cfg_rest_tk = val[23:0];
         REG_LOWER:   cfg_lower = val[15:0];
         REG_SHORT:   cfg_short = val[15:0];
         REG_LONG:    cfg_long = val[15:0];
         default: ;
      endcase
   endtask

   // wait until every sent beat has been taken and answered
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   function automatic item_t make_item(item_t raw);
      item_t it;
      int    pick;
      it = raw;
      pick = $urandom_range(99);
      if (pick < 50) it.kind = KIND_TICK;
      else if (pick < 72) it.kind = KIND_CELL;
      else if (pick < 95) it.kind = KIND_REQ;
      else it.kind = KIND_SPARE;
      // mostly well-formed requests: init early, then moves among states
      if (it.kind == KIND_REQ && $urandom_range(9) < 8) begin
         if (mdl_main == ST_UNINIT) it.code = RQ_INIT;
         else it.code = 3'($urandom_range(6, 1));
      end
      if ($urandom_range(9) < 8) begin
         it.minv = 16'(base_mv + $urandom_range(20));
         it.volt = 16'(base_mv + $urandom_range(80));
         it.cur = 20'($urandom_range(300)) * ($urandom_range(1) ? 20'd1 : -20'd1);
      end
      return it;
   endfunction

   row_t dir_rows [] = '{
      '{'{KIND_TICK, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_UNINIT},
      '{'{KIND_SPARE, RQ_ERROR, 4'd15, 16'hFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1, RS_OK,
        ST_UNINIT},
      '{'{KIND_REQ, RQ_ACTIVE, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_UNINIT},
      '{'{KIND_REQ, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING, ST_UNINIT},
      '{'{KIND_TICK, RQ_INIT, 4'd0, 16'd0, 20'h80000, 16'd0}, 1'b0, RS_OK, ST_UNINIT},
      '{'{KIND_REQ, RQ_ERROR, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_UNINIT},
      '{'{KIND_REQ, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING, ST_UNINIT},
      '{'{KIND_TICK, RQ_INIT, 4'd0, 16'd0, 20'h7FFFF, 16'hFFFF}, 1'b0, RS_OK,
        ST_UNINIT},
      '{'{KIND_REQ, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_UNINIT},
      '{'{KIND_TICK, RQ_INIT, 4'd0, 16'd0, 20'd5, 16'd3000}, 1'b1, RS_OK, ST_INIT},
      '{'{KIND_REQ, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_ALREADY, ST_INIT},
      '{'{KIND_CELL, RQ_INIT, 4'd15, 16'hFFFF, 20'd0, 16'd0}, 1'b1, RS_OK, ST_INIT},
      '{'{KIND_CELL, RQ_INIT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_INIT},
      '{'{KIND_CELL, RQ_INIT, 4'd7, 16'd4000, 20'd0, 16'd0}, 1'b0, RS_OK, ST_INIT},
      '{'{KIND_REQ, RQ_ACT_OVR, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_OK, ST_INIT},
      '{'{KIND_REQ, RQ_INACT_OVR, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING,
        ST_INIT},
      '{'{KIND_REQ, RQ_INACTIVE, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING,
        ST_INIT},
      '{'{KIND_REQ, RQ_STOP_TO_ACT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING,
        ST_INIT},
      '{'{KIND_REQ, RQ_STOP_TO_INACT, 4'd0, 16'd0, 20'd0, 16'd0}, 1'b1, RS_PENDING,
        ST_INIT},
      '{'{KIND_TICK, RQ_INIT, 4'd0, 16'd0, 20'hFFF38, 16'd3000}, 1'b0, RS_OK, ST_INIT}
   };

   initial begin
      item_t raw;
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at reset settings
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed,
                                      dir_rows[i].status, dir_rows[i].main);
      drain();

      // random phases, each under a new register setting
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_THRESH, 0); csr_write(REG_HYST, 0);
               csr_write(REG_REST_MA, 0); csr_write(REG_REST_TK, 0);
               csr_write(REG_LOWER, 0); csr_write(REG_SHORT, 0);
               csr_write(REG_LONG, 0);
            end
            1: begin
               csr_write(REG_THRESH, 16'hFFFF); csr_write(REG_HYST, 16'hFFFF);
               csr_write(REG_REST_MA, 19'h7FFFF); csr_write(REG_REST_TK, 24'hFFFFFF);
               csr_write(REG_LOWER, 16'hFFFF); csr_write(REG_SHORT, 1);
               csr_write(REG_LONG, 16'hFFFF);
            end
            default: begin
               csr_write(REG_THRESH, $urandom_range(40));
               csr_write(REG_HYST, $urandom_range(30));
               csr_write(REG_REST_MA, $urandom_range(400, 50));
               csr_write(REG_REST_TK, $urandom_range(12));
               csr_write(REG_LOWER, $urandom_range(3300, 2900));
               csr_write(REG_SHORT, $urandom_range(3));
               csr_write(REG_LONG, $urandom_range(8));
            end
         endcase
         base_mv = $urandom_range(3600, 2800);
         quiet = (ph == 8);
         for (int n = 0; n < 150; n++) begin
            raw = item_t'(61'({$urandom, $urandom}));
            send_item(make_item(raw), 1'b0, RS_OK, ST_UNINIT);
         end
         drain();
      end

      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
